// ===== src/bsm_pkg.sv =====
`timescale 1ns / 1ps
// Package with the item types, codes and constants of the bank switch mapper.
package bsm_pkg;

	localparam int BANK_REG_COUNT_DEF = 8;

	localparam logic [2:0] KIND_CPU_RD = 3'd0;
	localparam logic [2:0] KIND_CPU_WR = 3'd1;
	localparam logic [2:0] KIND_PAT_RD = 3'd2;
	localparam logic [2:0] KIND_PAT_WR = 3'd3;
	localparam logic [2:0] KIND_TICK   = 3'd4;

	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_PRG  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;
	localparam logic [1:0] TGT_CHR  = 2'd3;

	localparam logic [1:0] REG_PRG_BANK_COUNT = 2'd0;
	localparam logic [1:0] REG_CHR_IS_RAM     = 2'd1;
	localparam logic [1:0] REG_HEADER_MIRROR  = 2'd2;

	localparam logic [6:0] PRG_BANK_COUNT_RST = 7'd16;
	localparam logic [7:0] RAM_LOCK_MASK      = 8'hC0;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        line_visible;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [18:0] memory_address;
		logic        write_enable;
		logic        irq_fire;
		logic        mirror_mode;
	} out_item_t;

endpackage

// ===== src/bank_switch_mapper_with_scanline_irq_top.sv =====
`timescale 1ns / 1ps
// Top level of the cartridge bank mapper with its scanline interrupt counter.
// An accepted item's result is registered in the output register, or in the skid
// register during an output stall. Throughput: one item per cycle while the skid
// register is empty, so the two-entry output takes one more item while stalled.
// Reset: bank registers clear except R7 = 1, mode and IRQ state clear, and the
// configuration registers take their defaults (16 banks, CHR ROM, mirror 0).
module bank_switch_mapper_with_scanline_irq_top #(
	parameter int BANK_REG_COUNT = bsm_pkg::BANK_REG_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bsm_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output bsm_pkg::out_item_t out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import bsm_pkg::*;

	localparam int IDX_W = $clog2(BANK_REG_COUNT);

	logic [7:0]  bank_regs_q [BANK_REG_COUNT];
	logic [2:0]  bank_index_q;
	logic        prg_swap_q;
	logic        chr_swap_q;
	logic        mirror_q;
	logic        ram_locked_q;
	logic [7:0]  irq_reload_q;
	logic [7:0]  irq_count_q;
	logic        irq_armed_q;
	logic [6:0]  prg_bank_count_q;
	logic        chr_is_ram_q;
	logic        header_mirror_q;

	logic        out_valid_q;
	logic        skid_valid_q;
	out_item_t   out_item_q;
	out_item_t   skid_item_q;

	logic        accept;
	logic        out_free;
	logic        cfg_wr;
	out_item_t   result;

	logic        reg_wr;
	logic        odd;
	logic [5:0]  last_bank;
	logic [5:0]  second_bank;
	logic [5:0]  rom_bank;
	logic [2:0]  slot;
	logic [2:0]  chr_idx;
	logic [7:0]  chr_sel;
	logic [7:0]  chr_bank;
	logic        mirror_d;
	logic [7:0]  count_dec;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_PRG_BANK_COUNT: prdata = {25'd0, prg_bank_count_q};
			REG_CHR_IS_RAM:     prdata = {31'd0, chr_is_ram_q};
			REG_HEADER_MIRROR:  prdata = {31'd0, header_mirror_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign odd         = in_item.address[0];
	assign reg_wr      = (in_item.kind == KIND_CPU_WR) && in_item.address[15];
	assign last_bank   = prg_bank_count_q[5:0] - 6'd1;
	assign second_bank = prg_bank_count_q[5:0] - 6'd2;
	assign count_dec   = irq_count_q - 8'd1;

	always_comb begin
		case (in_item.address[14:13])
			2'b11:   rom_bank = last_bank;
			2'b10:   rom_bank = prg_swap_q ? bank_regs_q[6][5:0] : second_bank;
			2'b01:   rom_bank = bank_regs_q[7][5:0];
			default: rom_bank = prg_swap_q ? last_bank : bank_regs_q[6][5:0];
		endcase
	end

	assign slot    = in_item.address[12:10] ^ {chr_swap_q, 2'b00};
	assign chr_idx = slot[2] ? (slot - 3'd2) : {2'b00, slot[1]};
	assign chr_sel = bank_regs_q[chr_idx[IDX_W-1:0]];
	assign chr_bank = slot[2] ? chr_sel : {chr_sel[7:1], slot[0]};

	assign mirror_d = (reg_wr && in_item.address[14:13] == 2'b01 && !odd)
		? in_item.write_data[0] : mirror_q;

	always_comb begin
		result                = '0;
		result.mirror_mode    = mirror_d;
		case (in_item.kind)
			KIND_CPU_RD, KIND_CPU_WR: begin
				if (in_item.address[15:13] == 3'b011) begin
					result.target         = TGT_RAM;
					result.memory_address = {6'd0, in_item.address[12:0]};
					result.write_enable   = (in_item.kind == KIND_CPU_WR) && !ram_locked_q;
				end else if (in_item.address[15] && in_item.kind == KIND_CPU_RD) begin
					result.target         = TGT_PRG;
					result.memory_address = {rom_bank, in_item.address[12:0]};
				end
			end
			KIND_PAT_RD, KIND_PAT_WR: begin
				result.target         = TGT_CHR;
				result.memory_address = {1'b0, chr_bank, in_item.address[9:0]};
				result.write_enable   = (in_item.kind == KIND_PAT_WR) && chr_is_ram_q;
			end
			KIND_TICK: begin
				result.irq_fire = irq_armed_q && in_item.line_visible
					&& (irq_count_q != 8'd0) && (count_dec == 8'd0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_REG_COUNT; i++) begin
				bank_regs_q[i] <= (i == 7) ? 8'd1 : 8'd0;
			end
			bank_index_q     <= '0;
			prg_swap_q       <= 1'b0;
			chr_swap_q       <= 1'b0;
			mirror_q         <= 1'b0;
			ram_locked_q     <= 1'b0;
			irq_reload_q     <= '0;
			irq_count_q      <= '0;
			irq_armed_q      <= 1'b0;
			prg_bank_count_q <= PRG_BANK_COUNT_RST;
			chr_is_ram_q     <= 1'b0;
			header_mirror_q  <= 1'b0;
		end else begin
			if (accept) begin
				mirror_q <= mirror_d;
				if (reg_wr) begin
					case (in_item.address[14:13])
						2'b00: begin
							if (!odd) begin
								bank_index_q <= in_item.write_data[2:0];
								prg_swap_q   <= in_item.write_data[6];
								chr_swap_q   <= in_item.write_data[7];
							end else begin
								bank_regs_q[bank_index_q[IDX_W-1:0]] <= in_item.write_data;
							end
						end
						2'b01: begin
							if (odd) begin
								ram_locked_q <= (in_item.write_data & RAM_LOCK_MASK) != 8'd0;
							end
						end
						2'b10: begin
							if (!odd) begin
								irq_reload_q <= in_item.write_data;
							end else begin
								irq_count_q <= '0;
							end
						end
						default: irq_armed_q <= odd;
					endcase
				end
				if (in_item.kind == KIND_TICK && irq_armed_q && in_item.line_visible) begin
					irq_count_q <= (irq_count_q == 8'd0) ? irq_reload_q : count_dec;
				end
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_PRG_BANK_COUNT: prg_bank_count_q <= pwdata[6:0];
					REG_CHR_IS_RAM:     chr_is_ram_q     <= pwdata[0];
					REG_HEADER_MIRROR: begin
						header_mirror_q <= pwdata[0];
						mirror_q        <= pwdata[0];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_item_q <= skid_item_q;
			end else if (accept) begin
				out_item_q <= result;
			end
		end else if (accept) begin
			skid_item_q <= result;
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid register holds an item while the output register is empty.");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("Skid register filled without an output stall.");

	a_fire_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.irq_fire) |-> (out_item_q.target == TGT_NONE))
		else $error("IRQ pulse reported with a memory target.");

	a_we_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.write_enable) |->
			(out_item_q.target == TGT_RAM || out_item_q.target == TGT_CHR))
		else $error("Write enable raised for a target that cannot be written.");

endmodule

// ===== verif/bank_switch_mapper_with_scanline_irq_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the bank mapper: predicts every translated access and compares it.
module bank_switch_mapper_with_scanline_irq_top_tb;
	import bsm_pkg::*;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 90;
	localparam int unsigned SEG_ITEMS = 112;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bank_switch_mapper_with_scanline_irq_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Cartridge setting and mapper state as the predictor sees them.
	logic [6:0] cart_banks = PRG_BANK_COUNT_RST;
	logic cart_chr_ram = 1'b0;
	logic cart_hdr_mirror = 1'b0;
	logic [7:0] bank_regs [0:BANK_REG_COUNT_DEF-1];
	logic [2:0] bank_sel = '0;
	logic prg_swap = 1'b0;
	logic chr_swap = 1'b0;
	logic mirror_bit = 1'b0;
	logic ram_locked = 1'b0;
	logic [7:0] irq_reload = '0;
	logic [7:0] irq_count = '0;
	logic irq_armed = 1'b0;

	in_item_t pending_accesses[$];
	out_item_t predicted_results[$];

	int unsigned tx_idle_pct = 28;
	int unsigned rx_idle_pct = 62;
	logic rx_hold = 1'b0;
	logic hold_go = 1'b0;
	int unsigned accesses_queued = 0;
	int unsigned accesses_sent = 0;
	int unsigned results_seen = 0;
	int unsigned irq_pulses = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	function automatic out_item_t translate_access(input in_item_t it);
		out_item_t r;
		logic [6:0] last7;
		logic [6:0] second7;
		logic [5:0] bank6;
		logic [2:0] slot;
		logic [7:0] cbank;
		r = '0;
		last7 = cart_banks - 7'd1;
		second7 = cart_banks - 7'd2;
		case (it.kind)
			KIND_CPU_RD, KIND_CPU_WR: begin
				if (it.address[15:13] == 3'b011) begin
					r.target = TGT_RAM;
					r.memory_address = {6'd0, it.address[12:0]};
					r.write_enable = (it.kind == KIND_CPU_WR) && !ram_locked;
				end else if (it.address[15] && it.kind == KIND_CPU_RD) begin
					case (it.address[14:13])
						2'd3: bank6 = last7[5:0];
						2'd2: bank6 = prg_swap ? bank_regs[6][5:0] : second7[5:0];
						2'd1: bank6 = bank_regs[7][5:0];
						default: bank6 = prg_swap ? last7[5:0] : bank_regs[6][5:0];
					endcase
					r.target = TGT_PRG;
					r.memory_address = {bank6, it.address[12:0]};
				end else if (it.address[15]) begin
					case (it.address[14:13])
						2'd0: begin
							if (!it.address[0]) begin
								bank_sel = it.write_data[2:0];
								prg_swap = it.write_data[6];
								chr_swap = it.write_data[7];
							end else begin
								bank_regs[bank_sel] = it.write_data;
							end
						end
						2'd1: begin
							if (!it.address[0]) begin
								mirror_bit = it.write_data[0];
							end else begin
								ram_locked = |(it.write_data & RAM_LOCK_MASK);
							end
						end
						2'd2: begin
							if (!it.address[0]) begin
								irq_reload = it.write_data;
							end else begin
								irq_count = '0;
							end
						end
						default: irq_armed = it.address[0];
					endcase
				end
			end
			KIND_PAT_RD, KIND_PAT_WR: begin
				slot = it.address[12:10] ^ {chr_swap, 2'b00};
				if (!slot[2]) begin
					cbank = {bank_regs[{2'b00, slot[1]}][7:1], slot[0]};
				end else begin
					cbank = bank_regs[slot - 3'd2];
				end
				r.target = TGT_CHR;
				r.memory_address = {1'b0, cbank, it.address[9:0]};
				r.write_enable = (it.kind == KIND_PAT_WR) && cart_chr_ram;
			end
			KIND_TICK: begin
				if (irq_armed && it.line_visible) begin
					if (irq_count == 8'd0) begin
						irq_count = irq_reload;
					end else begin
						irq_count = irq_count - 8'd1;
						r.irq_fire = (irq_count == 8'd0);
					end
				end
			end
			default: ;
		endcase
		r.mirror_mode = mirror_bit;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("Mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
			end
		end
	endtask

	task automatic cart_reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] val,
			output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr) begin
			case (idx)
				REG_PRG_BANK_COUNT: cart_banks = val[6:0];
				REG_CHR_IS_RAM: cart_chr_ram = val[0];
				REG_HEADER_MIRROR: begin
					cart_hdr_mirror = val[0];
					mirror_bit = val[0];
				end
				default: ;
			endcase
		end
	endtask

	task automatic verify_cart_reg(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] rd;
		cart_reg_access(1'b0, idx, '0, rd);
		check_field($sformatf("readback of register %0d", idx), want, rd);
	endtask

	task automatic set_cart_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		cart_reg_access(1'b1, idx, val, rd);
		verify_cart_reg(idx, (idx == REG_PRG_BANK_COUNT) ? {25'd0, val[6:0]} : {31'd0, val[0]});
	endtask

	task automatic queue_access(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
			input logic v);
		in_item_t it;
		it.kind = k;
		it.address = a;
		it.write_data = d;
		it.line_visible = v;
		pending_accesses.push_back(it);
		accesses_queued++;
	endtask

	// Register writes hit a random address within the chosen 8KB window.
	function automatic logic [15:0] reg_addr(input logic [1:0] window, input logic odd);
		return {1'b1, window, 12'($urandom()), odd};
	endfunction

	task automatic queue_random_segment(input int unsigned count);
		int unsigned start;
		int unsigned n;
		int unsigned i;
		start = accesses_queued;
		while (accesses_queued - start < count) begin
			case ($urandom_range(11))
				0, 1: begin
					queue_access(KIND_CPU_WR, reg_addr(2'd0, 1'b0), 8'($urandom()), 1'($urandom()));
					queue_access(KIND_CPU_WR, reg_addr(2'd0, 1'b1), 8'($urandom()), 1'($urandom()));
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++) begin
						if ($urandom_range(1)) begin
							queue_access(KIND_CPU_RD, {1'b1, 15'($urandom())}, 8'($urandom()),
								1'($urandom()));
						end else begin
							queue_access(KIND_PAT_RD, {3'b000, 13'($urandom())}, 8'($urandom()),
								1'($urandom()));
						end
					end
				end
				2, 3: begin
					queue_access(KIND_CPU_WR, reg_addr(2'd2, 1'b0), 8'($urandom_range(0, 5)),
						1'($urandom()));
					queue_access(KIND_CPU_WR, reg_addr(2'd2, 1'b1), 8'($urandom()), 1'($urandom()));
					queue_access(KIND_CPU_WR, reg_addr(2'd3, 1'b1), 8'($urandom()), 1'($urandom()));
					n = $urandom_range(3, 12);
					for (i = 0; i < n; i++) begin
						queue_access(KIND_TICK, 16'($urandom()), 8'($urandom()),
							$urandom_range(4) != 0);
					end
					if ($urandom_range(2) == 0) begin
						queue_access(KIND_CPU_WR, reg_addr(2'd3, 1'b0), 8'($urandom()),
							1'($urandom()));
					end
				end
				4: queue_access(KIND_CPU_RD, 16'($urandom()), 8'($urandom()), 1'($urandom()));
				5: queue_access(KIND_CPU_RD, {1'b1, 15'($urandom())}, 8'($urandom()),
					1'($urandom()));
				6: queue_access(KIND_CPU_WR, $urandom_range(1) ? {3'b011, 13'($urandom())} :
					16'($urandom()), 8'($urandom()), 1'($urandom()));
				7: queue_access(KIND_CPU_WR, reg_addr(2'($urandom()), 1'($urandom())),
					8'($urandom()), 1'($urandom()));
				8, 9: queue_access($urandom_range(1) ? KIND_PAT_RD : KIND_PAT_WR,
					$urandom_range(4) == 0 ? 16'($urandom()) : {3'b000, 13'($urandom())},
					8'($urandom()), 1'($urandom()));
				10: queue_access(KIND_TICK, 16'($urandom()), 8'($urandom()), $urandom_range(3) != 0);
				default: queue_access(3'($urandom_range(5, 7)), 16'($urandom()), 8'($urandom()),
					1'($urandom()));
			endcase
		end
	endtask

	task automatic wait_drained();
		while (pending_accesses.size() != 0 || in_valid || predicted_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted_results.push_back(translate_access(in_item));
				accesses_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_accesses.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_item <= pending_accesses.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Unexpected result 0x%0h with nothing predicted", out_item);
					end
				end else begin
					want = predicted_results.pop_front();
					check_field($sformatf("result %0d target", results_seen),
						32'(want.target), 32'(out_item.target));
					check_field($sformatf("result %0d memory_address", results_seen),
						32'(want.memory_address), 32'(out_item.memory_address));
					check_field($sformatf("result %0d write_enable", results_seen),
						32'(want.write_enable), 32'(out_item.write_enable));
					check_field($sformatf("result %0d irq_fire", results_seen),
						32'(want.irq_fire), 32'(out_item.irq_fire));
					check_field($sformatf("result %0d mirror_mode", results_seen),
						32'(want.mirror_mode), 32'(out_item.mirror_mode));
				end
				results_seen++;
				if (out_item.irq_fire) irq_pulses++;
			end
			out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
		end
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int seg;
		logic [6:0] banks;
		logic chr;
		logic mir;
		for (int i = 0; i < BANK_REG_COUNT_DEF; i++) bank_regs[i] = 8'd0;
		bank_regs[7] = 8'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_cart_reg(REG_PRG_BANK_COUNT, {25'd0, PRG_BANK_COUNT_RST});
		verify_cart_reg(REG_CHR_IS_RAM, 32'd0);
		verify_cart_reg(REG_HEADER_MIRROR, 32'd0);

		@(negedge clk);
		queue_access(KIND_CPU_RD, 16'h0000, 8'h00, 1'b0);
		queue_access(KIND_CPU_RD, 16'h5FFF, 8'hFF, 1'b1);
		queue_access(KIND_CPU_RD, 16'h6000, 8'h00, 1'b0);
		queue_access(KIND_CPU_WR, 16'h7FFF, 8'hFF, 1'b1);
		queue_access(KIND_CPU_RD, 16'h8000, 8'h00, 1'b0);
		queue_access(KIND_CPU_RD, 16'hA000, 8'h00, 1'b0);
		queue_access(KIND_CPU_RD, 16'hDFFF, 8'h00, 1'b0);
		queue_access(KIND_CPU_RD, 16'hFFFF, 8'h00, 1'b0);
		queue_access(KIND_CPU_WR, 16'h8000, 8'hC7, 1'b0);
		queue_access(KIND_CPU_WR, 16'h8001, 8'hFF, 1'b0);
		queue_access(KIND_CPU_WR, 16'h8000, 8'hC2, 1'b0);
		queue_access(KIND_CPU_WR, 16'h9FFF, 8'hFF, 1'b0);
		queue_access(KIND_CPU_RD, 16'h8000, 8'h00, 1'b0);
		queue_access(KIND_CPU_RD, 16'hA123, 8'h00, 1'b0);
		queue_access(KIND_CPU_RD, 16'hC000, 8'h00, 1'b0);
		queue_access(KIND_PAT_RD, 16'h0000, 8'h00, 1'b0);
		queue_access(KIND_PAT_RD, 16'hFFFF, 8'h00, 1'b0);
		queue_access(KIND_PAT_WR, 16'h1C00, 8'h5A, 1'b0);
		queue_access(KIND_CPU_WR, 16'hA000, 8'h01, 1'b0);
		queue_access(KIND_CPU_WR, 16'hA001, 8'h80, 1'b0);
		queue_access(KIND_CPU_WR, 16'h6000, 8'h00, 1'b0);
		queue_access(KIND_CPU_WR, 16'hC000, 8'h02, 1'b0);
		queue_access(KIND_CPU_WR, 16'hC001, 8'h00, 1'b0);
		queue_access(KIND_TICK, 16'h0000, 8'h00, 1'b1);
		queue_access(KIND_CPU_WR, 16'hE001, 8'h00, 1'b0);
		queue_access(KIND_TICK, 16'h0000, 8'h00, 1'b0);
		repeat (3) queue_access(KIND_TICK, 16'hFFFF, 8'hFF, 1'b1);
		queue_access(KIND_CPU_WR, 16'hE000, 8'h00, 1'b0);
		queue_access(3'd7, 16'hFFFF, 8'hFF, 1'b1);
		wait_drained();

		for (seg = 0; seg < 6; seg++) begin
			case (seg)
				0: begin banks = 7'd2; chr = 1'b1; mir = 1'b1; end
				1: begin banks = 7'd64; chr = 1'b0; mir = 1'b0; end
				2: begin banks = 7'd0; chr = 1'b1; mir = 1'b0; end
				3: begin banks = 7'd127; chr = 1'b0; mir = 1'b1; end
				4: begin banks = 7'd1; chr = 1'b1; mir = 1'b1; end
				default: begin
					banks = 7'($urandom_range(2, 64));
					chr = 1'($urandom());
					mir = 1'($urandom());
				end
			endcase
			set_cart_reg(REG_PRG_BANK_COUNT, ($urandom() & 32'hFFFF_FF80) | {25'd0, banks});
			set_cart_reg(REG_CHR_IS_RAM, ($urandom() & 32'hFFFF_FFFE) | {31'd0, chr});
			set_cart_reg(REG_HEADER_MIRROR, ($urandom() & 32'hFFFF_FFFE) | {31'd0, mir});
			@(negedge clk);
			if (seg < 2) begin
				tx_idle_pct = 28;
				rx_idle_pct = 62;
			end else if (seg < 4) begin
				tx_idle_pct = 62;
				rx_idle_pct = 28;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			queue_random_segment(SEG_ITEMS);
			if (seg == 4) hold_go = 1'b1;
			wait_drained();
		end

		$display("Covered %0d items and %0d results over seven cartridge settings,", accesses_sent,
			results_seen);
		$display("including %0d scanline interrupt pulses and a long output hold-off.", irq_pulses);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
